>>> rtl/core/pibps_pkg.sv
// shared types and constants for the point-in-box priority select block
// no dependencies; used by the interfaces and every module under rtl/core
package pibps_pkg;

   localparam int COORD_BITS = 24;
   localparam int ID_BITS    = 16;
   localparam int PRIO_BITS  = 8;
   localparam int DIFF_BITS  = COORD_BITS + 3;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PRIO_BITS-1:0]  prio_type;
   typedef logic [ID_BITS-1:0]           id_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [DIST_BITS-1:0]         dist_val_type;

   localparam prio_type MIN_PRIO_RESET = {1'b1, {(PRIO_BITS-1){1'b0}}};

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_BOX   = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_REAL    = 2'd0,
      KIND_VIRTUAL = 2'd1,
      KIND_LAST    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      action_type action;
      coord_type  ax;
      coord_type  ay;
      coord_type  az;
      coord_type  bx;
      coord_type  by;
      coord_type  bz;
      prio_type   box_priority;
      logic       box_virt;
      id_type     box_id;
      logic       last;
   } req_type;

   typedef struct packed {
      logic     start;
      logic     last;
      logic     hit;
      logic     box_virt;
      prio_type box_priority;
      id_type   box_id;
      mag_type  mag_x;
      mag_type  mag_y;
      mag_type  mag_z;
   } geom_type;

   typedef struct packed {
      logic         start;
      logic         last;
      logic         hit;
      logic         box_virt;
      prio_type     box_priority;
      id_type       box_id;
      dist_val_type sq_dist;
   } dist_type;

endpackage

>>> rtl/core/pibps_if.sv
// request and response channel interfaces, valid/ready handshake
// depends on pibps_pkg for field types
interface pibps_req_if;
   logic                  valid;
   logic                  ready;
   logic                  action;
   pibps_pkg::coord_type  ax;
   pibps_pkg::coord_type  ay;
   pibps_pkg::coord_type  az;
   pibps_pkg::coord_type  bx;
   pibps_pkg::coord_type  by;
   pibps_pkg::coord_type  bz;
   pibps_pkg::prio_type   box_priority;
   logic                  box_virt;
   pibps_pkg::id_type     box_id;
   logic                  last;

   modport source (
      output valid, action, ax, ay, az, bx, by, bz, box_priority, box_virt, box_id, last,
      input  ready
   );
   modport sink (
      input  valid, action, ax, ay, az, bx, by, bz, box_priority, box_virt, box_id, last,
      output ready
   );
endinterface

interface pibps_rsp_if;
   logic                  valid;
   logic                  ready;
   pibps_pkg::id_type     chosen_id;
   logic [1:0]            choice_kind;

   modport source (
      output valid, chosen_id, choice_kind,
      input  ready
   );
   modport sink (
      input  valid, chosen_id, choice_kind,
      output ready
   );
endinterface

>>> rtl/core/pibps_front.sv
// request register, query point register, containment test and centre offsets
// depends on pibps_pkg and pibps_req_if
module pibps_front (
   input  logic                 clock,
   input  logic                 reset,
   pibps_req_if.sink            req,
   output logic                 geo_valid,
   input  logic                 geo_ready,
   output pibps_pkg::geom_type  geo_data
);

   logic                 s1_valid_ff, s1_valid_in;
   pibps_pkg::req_type   s1_ff;
   logic                 s2_valid_ff, s2_valid_in;
   pibps_pkg::geom_type  s2_ff, s2_in;
   pibps_pkg::coord_type point_x_ff, point_x_in;
   pibps_pkg::coord_type point_y_ff, point_y_in;
   pibps_pkg::coord_type point_z_ff, point_z_in;
   logic                 req_take;
   logic                 ld2;
   logic                 is_start;

   function automatic pibps_pkg::mag_type center_mag(
      input pibps_pkg::coord_type p,
      input pibps_pkg::coord_type a,
      input pibps_pkg::coord_type b
   );
      pibps_pkg::diff_type d;
      d = (pibps_pkg::diff_type'(p) <<< 1) - pibps_pkg::diff_type'(a)
          - pibps_pkg::diff_type'(b);
      return d[pibps_pkg::DIFF_BITS-1] ? pibps_pkg::mag_type'(-d) : pibps_pkg::mag_type'(d);
   endfunction

   assign ld2       = s1_valid_ff && (!s2_valid_ff || geo_ready);
   assign req.ready = !s1_valid_ff || ld2;
   assign req_take  = req.valid && req.ready;
   assign is_start  = (s1_ff.action == pibps_pkg::ACT_START);

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (ld2 ? 1'b0 : s1_valid_ff);
      s2_valid_in = ld2 ? 1'b1 : (geo_ready ? 1'b0 : s2_valid_ff);

      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      point_z_in = point_z_ff;
      if (ld2 && is_start) begin
         point_x_in = s1_ff.ax;
         point_y_in = s1_ff.ay;
         point_z_in = s1_ff.az;
      end

      s2_in.start        = is_start;
      s2_in.last         = s1_ff.last;
      s2_in.hit          = (s1_ff.ax <= point_x_ff) && (point_x_ff <= s1_ff.bx) &&
                           (s1_ff.ay <= point_y_ff) && (point_y_ff <= s1_ff.by) &&
                           (s1_ff.az <= point_z_ff) && (point_z_ff <= s1_ff.bz);
      s2_in.box_virt     = s1_ff.box_virt;
      s2_in.box_priority = s1_ff.box_priority;
      s2_in.box_id       = s1_ff.box_id;
      s2_in.mag_x        = center_mag(point_x_ff, s1_ff.ax, s1_ff.bx);
      s2_in.mag_y        = center_mag(point_y_ff, s1_ff.ay, s1_ff.by);
      s2_in.mag_z        = center_mag(point_z_ff, s1_ff.az, s1_ff.bz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         point_x_ff  <= '0;
         point_y_ff  <= '0;
         point_z_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         point_x_ff  <= point_x_in;
         point_y_ff  <= point_y_in;
         point_z_ff  <= point_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.action       <= pibps_pkg::action_type'(req.action);
         s1_ff.ax           <= req.ax;
         s1_ff.ay           <= req.ay;
         s1_ff.az           <= req.az;
         s1_ff.bx           <= req.bx;
         s1_ff.by           <= req.by;
         s1_ff.bz           <= req.bz;
         s1_ff.box_priority <= req.box_priority;
         s1_ff.box_virt     <= req.box_virt;
         s1_ff.box_id       <= req.box_id;
         s1_ff.last         <= req.last;
      end
      if (ld2) begin
         s2_ff <= s2_in;
      end
   end

   assign geo_valid = s2_valid_ff;
   assign geo_data  = s2_ff;

endmodule

>>> rtl/core/pibps_dist.sv
// squared centre distance: one register after the squares, one after the sum
// depends on pibps_pkg
module pibps_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 geo_valid,
   output logic                 geo_ready,
   input  pibps_pkg::geom_type  geo_data,
   output logic                 dst_valid,
   input  logic                 dst_ready,
   output pibps_pkg::dist_type  dst_data
);

   typedef struct packed {
      logic                 start;
      logic                 last;
      logic                 hit;
      logic                 box_virt;
      pibps_pkg::prio_type  box_priority;
      pibps_pkg::id_type    box_id;
      pibps_pkg::sq_type    sq_x;
      pibps_pkg::sq_type    sq_y;
      pibps_pkg::sq_type    sq_z;
   } sq_stage_type;

   logic                s3_valid_ff, s3_valid_in;
   sq_stage_type        s3_ff, s3_in;
   logic                s4_valid_ff, s4_valid_in;
   pibps_pkg::dist_type s4_ff, s4_in;
   logic                ld3, ld4;

   assign ld4       = s3_valid_ff && (!s4_valid_ff || dst_ready);
   assign geo_ready = !s3_valid_ff || ld4;
   assign ld3       = geo_valid && geo_ready;

   always_comb begin
      s3_valid_in = ld3 ? 1'b1 : (ld4 ? 1'b0 : s3_valid_ff);
      s4_valid_in = ld4 ? 1'b1 : (dst_ready ? 1'b0 : s4_valid_ff);

      s3_in.start        = geo_data.start;
      s3_in.last         = geo_data.last;
      s3_in.hit          = geo_data.hit;
      s3_in.box_virt     = geo_data.box_virt;
      s3_in.box_priority = geo_data.box_priority;
      s3_in.box_id       = geo_data.box_id;
      s3_in.sq_x = pibps_pkg::sq_type'(geo_data.mag_x) * pibps_pkg::sq_type'(geo_data.mag_x);
      s3_in.sq_y = pibps_pkg::sq_type'(geo_data.mag_y) * pibps_pkg::sq_type'(geo_data.mag_y);
      s3_in.sq_z = pibps_pkg::sq_type'(geo_data.mag_z) * pibps_pkg::sq_type'(geo_data.mag_z);

      s4_in.start        = s3_ff.start;
      s4_in.last         = s3_ff.last;
      s4_in.hit          = s3_ff.hit;
      s4_in.box_virt     = s3_ff.box_virt;
      s4_in.box_priority = s3_ff.box_priority;
      s4_in.box_id       = s3_ff.box_id;
      s4_in.sq_dist      = pibps_pkg::dist_val_type'(s3_ff.sq_x)
                         + pibps_pkg::dist_val_type'(s3_ff.sq_y)
                         + pibps_pkg::dist_val_type'(s3_ff.sq_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_ff <= s3_in;
      end
      if (ld4) begin
         s4_ff <= s4_in;
      end
   end

   assign dst_valid = s4_valid_ff;
   assign dst_data  = s4_ff;

endmodule

>>> rtl/core/pibps_select.sv
// running best real and virtual box, final choice and response register
// depends on pibps_pkg and pibps_rsp_if
module pibps_select (
   input  logic                 clock,
   input  logic                 reset,
   input  pibps_pkg::prio_type  min_priority,
   input  logic                 dst_valid,
   output logic                 dst_ready,
   input  pibps_pkg::dist_type  dst_data,
   pibps_rsp_if.source          rsp
);

   logic                    real_found_ff, real_found_in;
   pibps_pkg::id_type       real_id_ff, real_id_in;
   pibps_pkg::prio_type     real_prio_ff, real_prio_in;
   pibps_pkg::dist_val_type real_dist_ff, real_dist_in;
   logic                    virt_found_ff, virt_found_in;
   pibps_pkg::id_type       virt_id_ff, virt_id_in;
   pibps_pkg::prio_type     virt_prio_ff, virt_prio_in;
   pibps_pkg::dist_val_type virt_dist_ff, virt_dist_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pibps_pkg::id_type       rsp_id_ff, rsp_id_in;
   pibps_pkg::kind_type     rsp_kind_ff, rsp_kind_in;
   pibps_pkg::prio_type     best_real, best_virt;
   logic                    take, emit, is_box;
   logic                    take_real, take_virt;
   logic                    win_real, win_virt;
   pibps_pkg::id_type       win_real_id, win_virt_id;

   assign dst_ready = !dst_data.last || !rsp_valid_ff || rsp.ready;
   assign take      = dst_valid && dst_ready;
   assign emit      = take && dst_data.last;
   assign is_box    = !dst_data.start;

   always_comb begin
      best_real = real_found_ff ? real_prio_ff : min_priority;
      best_virt = virt_found_ff ? virt_prio_ff : min_priority;

      take_real = take && is_box && dst_data.hit && !dst_data.box_virt &&
                  ((dst_data.box_priority > best_real) ||
                   ((dst_data.box_priority == best_real) &&
                    (!real_found_ff || (dst_data.sq_dist < real_dist_ff))));
      take_virt = take && is_box && dst_data.hit && dst_data.box_virt &&
                  ((dst_data.box_priority > best_virt) ||
                   ((dst_data.box_priority == best_virt) &&
                    (!virt_found_ff || (dst_data.sq_dist < virt_dist_ff))));

      win_real    = real_found_ff || take_real;
      win_virt    = virt_found_ff || take_virt;
      win_real_id = take_real ? dst_data.box_id : real_id_ff;
      win_virt_id = take_virt ? dst_data.box_id : virt_id_ff;

      real_id_in   = win_real_id;
      real_prio_in = take_real ? dst_data.box_priority : real_prio_ff;
      real_dist_in = take_real ? dst_data.sq_dist : real_dist_ff;
      virt_id_in   = win_virt_id;
      virt_prio_in = take_virt ? dst_data.box_priority : virt_prio_ff;
      virt_dist_in = take_virt ? dst_data.sq_dist : virt_dist_ff;

      // a start or a last item closes the current query
      if (take && (dst_data.start || dst_data.last)) begin
         real_found_in = 1'b0;
         virt_found_in = 1'b0;
      end else begin
         real_found_in = win_real;
         virt_found_in = win_virt;
      end

      priority if (dst_data.start) begin
         rsp_id_in   = '0;
         rsp_kind_in = pibps_pkg::KIND_NONE;
      end else if (win_real) begin
         rsp_id_in   = win_real_id;
         rsp_kind_in = pibps_pkg::KIND_REAL;
      end else if (win_virt) begin
         rsp_id_in   = win_virt_id;
         rsp_kind_in = pibps_pkg::KIND_VIRTUAL;
      end else begin
         rsp_id_in   = dst_data.box_id;
         rsp_kind_in = pibps_pkg::KIND_LAST;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_found_ff <= 1'b0;
         virt_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         real_found_ff <= real_found_in;
         virt_found_ff <= virt_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      real_id_ff   <= real_id_in;
      real_prio_ff <= real_prio_in;
      real_dist_ff <= real_dist_in;
      virt_id_ff   <= virt_id_in;
      virt_prio_ff <= virt_prio_in;
      virt_dist_ff <= virt_dist_in;
      if (emit) begin
         rsp_id_ff   <= rsp_id_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.chosen_id   = rsp_id_ff;
   assign rsp.choice_kind = rsp_kind_ff;

endmodule

>>> rtl/core/point_in_box_priority_select_top.sv
// Point-in-box priority select. A start request loads the query point; each box request that
// holds the point (bounds inclusive) competes in the real or virtual class, higher priority
// first, then nearer centre, earlier box on an exact tie. A request marked last yields one
// response: real winner, else virtual winner, else that box's own id, or none for a start.
// One request is taken every cycle unless a held response stalls the pipeline; a response
// becomes valid once its last request has passed the request register, containment and offsets
// register, squares register, distance sum register, then the winner update into the response
// register. The winner update loop sets the one-per-cycle rate.
// Write min_priority only while no request is in flight.
// depends on pibps_pkg, pibps_if, pibps_front, pibps_dist, pibps_select
module point_in_box_priority_select_top (
   input  logic                clock,
   input  logic                reset,
   pibps_req_if.sink           req_ch,
   pibps_rsp_if.source         rsp_ch,
   input  logic                csr_wr_en,
   input  pibps_pkg::prio_type csr_wr_data
);

   pibps_pkg::prio_type min_prio_ff, min_prio_in;
   logic                geo_valid, geo_ready;
   pibps_pkg::geom_type geo_data;
   logic                dst_valid, dst_ready;
   pibps_pkg::dist_type dst_data;

   assign min_prio_in = csr_wr_en ? csr_wr_data : min_prio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_prio_ff <= pibps_pkg::MIN_PRIO_RESET;
      end else begin
         min_prio_ff <= min_prio_in;
      end
   end

   pibps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .geo_valid (geo_valid),
      .geo_ready (geo_ready),
      .geo_data  (geo_data)
   );

   pibps_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .geo_valid (geo_valid),
      .geo_ready (geo_ready),
      .geo_data  (geo_data),
      .dst_valid (dst_valid),
      .dst_ready (dst_ready),
      .dst_data  (dst_data)
   );

   pibps_select u_select (
      .clock        (clock),
      .reset        (reset),
      .min_priority (min_prio_ff),
      .dst_valid    (dst_valid),
      .dst_ready    (dst_ready),
      .dst_data     (dst_data),
      .rsp          (rsp_ch)
   );

   // input stalls only behind an occupied offset stage
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> geo_valid)
      else $error("request stalled with empty offset stage");

   // the winner stage stalls only on a held response
   a_sel_stall: assert property (@(posedge clock) disable iff (reset)
      (dst_valid && !dst_ready) |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("winner stage stalled without a held response");

   // an empty query answers with id zero
   a_none_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.choice_kind == pibps_pkg::KIND_NONE)) |-> (rsp_ch.chosen_id == '0))
      else $error("none response with nonzero id");

endmodule
